FILE: sv/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and constants for the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int DefCapacity = 16;
  localparam int MaxResults  = 16;

  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_READ   = 3'd2,
    REQ_SEARCH = 3'd3,
    REQ_DUMP   = 3'd4
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // One result item as it leaves the block.
  typedef struct packed {
    status_t            status;
    logic signed [31:0] read_value;
    logic [3:0]         found_index;
    logic [4:0]         entry_count;
    logic               last;
  } pal_item_t;

  function automatic pal_item_t mk_item(status_t st, logic [31:0] val,
                                        logic [3:0] idx, logic lst);
    pal_item_t it;
    it.status      = st;
    it.read_value  = val;
    it.found_index = idx;
    it.entry_count = '0;
    it.last        = lst;
    return it;
  endfunction

endpackage

FILE: sv/pal_if.sv
// ----------------------------------------------------------------------------
// pal_req_if / pal_rsp_if
// Valid/ready channels for requests and result items.
// ----------------------------------------------------------------------------
interface pal_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [31:0] data_value;
  logic [4:0]         slot_index;

  modport source (output valid, req_type, data_value, slot_index, input ready);
  modport sink   (input valid, req_type, data_value, slot_index, output ready);
endinterface

interface pal_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] read_value;
  logic [3:0]         found_index;
  logic [4:0]         entry_count;
  logic               last;

  modport source (output valid, status, read_value, found_index, entry_count, last,
                  input ready);
  modport sink   (input valid, status, read_value, found_index, entry_count, last,
                  output ready);
endinterface

FILE: sv/pal_store.sv
// ----------------------------------------------------------------------------
// pal_store
// Entry memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pal_store #(
  parameter int CAPACITY = 16,
  parameter int AW       = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/pal_ctrl.sv
// ----------------------------------------------------------------------------
// pal_ctrl
// Request sequencer: walks the store one entry per step for shifts,
// searches and dumps, and hands result items to the output register.
// ----------------------------------------------------------------------------
module pal_ctrl #(
  parameter int CAPACITY = 16,
  parameter int AW       = 4,
  parameter int CW       = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [2:0]         req_type,
  input  logic [31:0]        data_value,
  input  logic [4:0]         slot_index,
  output logic               emit_valid,
  input  logic               emit_ready,
  output pal_pkg::pal_item_t emit_item
);
  import pal_pkg::*;

  localparam int CMPW = ((CW > 5) ? CW : 5) + 1;
  localparam logic [CMPW-1:0] CapC = CMPW'(CAPACITY);
  localparam logic [CMPW-1:0] MaxC = CMPW'(MaxResults);

  typedef enum logic [3:0] {
    S_IDLE, S_SH_RD, S_SH_WR, S_WR_NEW, S_RM_RD, S_RM_WR,
    S_RD_RD, S_RD_LAT, S_SR_RD, S_SR_CMP, S_DP_RD, S_DP_LAT, S_RESP
  } state_t;

  state_t          state;
  logic [31:0]     value;
  logic [CMPW-1:0] pos;
  logic [CW-1:0]   idx;
  logic [CW-1:0]   fill;
  logic [CMPW-1:0] dump_n;
  pal_item_t       res;

  logic            wr_en, rd_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [31:0]     wr_data, rd_data;
  logic [CMPW-1:0] fill_c, idx_c, pos_in;

  assign fill_c = CMPW'(fill);
  assign idx_c  = CMPW'(idx);
  assign pos_in = CMPW'(slot_index);

  assign req_ready  = (state == S_IDLE);
  assign emit_valid = (state == S_RESP);

  always_comb begin
    emit_item             = res;
    emit_item.entry_count = 5'(fill);
  end

  // Memory port steering
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = rd_data;
    rd_en   = 1'b0;
    rd_addr = idx[AW-1:0];
    unique case (state)
      S_SH_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(idx - 1'b1);
      end
      S_SH_WR, S_RM_WR: wr_en = 1'b1;
      S_WR_NEW: begin
        wr_en   = 1'b1;
        wr_addr = AW'(pos);
        wr_data = value;
      end
      S_RM_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(idx + 1'b1);
      end
      S_RD_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(pos);
      end
      S_SR_RD, S_DP_RD: rd_en = 1'b1;
      default: ;
    endcase
  end

  pal_store #(.CAPACITY(CAPACITY), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            value <= data_value;
            pos   <= pos_in;
            state <= S_RESP;
            res   <= mk_item(ST_BADPOS, '0, '0, 1'b1);
            case (req_type)
              REQ_INSERT: begin
                if (fill_c >= CapC) begin
                  res <= mk_item(ST_FULL, '0, '0, 1'b1);
                end else if (pos_in <= fill_c) begin
                  idx   <= fill;
                  state <= (pos_in == fill_c) ? S_WR_NEW : S_SH_RD;
                end
              end
              REQ_REMOVE: begin
                if (fill == '0) begin
                  res <= mk_item(ST_EMPTY, '0, '0, 1'b1);
                end else if (pos_in < fill_c) begin
                  idx <= CW'(pos_in);
                  if (pos_in + 1'b1 < fill_c) begin
                    state <= S_RM_RD;
                  end else begin
                    fill <= fill - 1'b1;
                    res  <= mk_item(ST_OK, '0, '0, 1'b1);
                  end
                end
              end
              REQ_READ: begin
                if (fill == '0) begin
                  res <= mk_item(ST_EMPTY, '0, '0, 1'b1);
                end else if (pos_in < fill_c) begin
                  state <= S_RD_RD;
                end
              end
              REQ_SEARCH: begin
                if (fill == '0) begin
                  res <= mk_item(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                  idx   <= '0;
                  state <= S_SR_RD;
                end
              end
              REQ_DUMP: begin
                if (fill == '0) begin
                  res <= mk_item(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                  idx    <= '0;
                  dump_n <= (fill_c > MaxC) ? MaxC : fill_c;
                  state  <= S_DP_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_SH_RD: state <= S_SH_WR;
        S_SH_WR: begin
          idx   <= idx - 1'b1;
          state <= (idx_c - 1'b1 == pos) ? S_WR_NEW : S_SH_RD;
        end
        S_WR_NEW: begin
          fill  <= fill + 1'b1;
          res   <= mk_item(ST_OK, '0, '0, 1'b1);
          state <= S_RESP;
        end
        S_RM_RD: state <= S_RM_WR;
        S_RM_WR: begin
          idx <= idx + 1'b1;
          if (idx_c + CMPW'(2) < fill_c) begin
            state <= S_RM_RD;
          end else begin
            fill  <= fill - 1'b1;
            res   <= mk_item(ST_OK, '0, '0, 1'b1);
            state <= S_RESP;
          end
        end
        S_RD_RD: state <= S_RD_LAT;
        S_RD_LAT: begin
          res   <= mk_item(ST_OK, rd_data, '0, 1'b1);
          state <= S_RESP;
        end
        S_SR_RD: state <= S_SR_CMP;
        S_SR_CMP: begin
          if (rd_data == value) begin
            res   <= mk_item(ST_OK, '0, 4'(idx), 1'b1);
            state <= S_RESP;
          end else if (idx_c + 1'b1 == fill_c) begin
            res   <= mk_item(ST_NOTFOUND, '0, '0, 1'b1);
            state <= S_RESP;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SR_RD;
          end
        end
        S_DP_RD: state <= S_DP_LAT;
        S_DP_LAT: begin
          res   <= mk_item(ST_OK, rd_data, 4'(idx), (idx_c + 1'b1 == dump_n));
          state <= S_RESP;
        end
        S_RESP: begin
          if (emit_ready) begin
            if (res.last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_DP_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/positional_array_list.sv
// ----------------------------------------------------------------------------
// positional_array_list
// Ordered list of signed 32-bit words with insert, remove, read, search, dump.
// ----------------------------------------------------------------------------
// Usage:
//   req : request items (req_type, data_value, slot_index), valid/ready.
//   rsp : result items (status, read_value, found_index, entry_count, last).
//   Every request yields one result item; a dump yields one per entry (at
//   most 16), with last set on the final one.
// Sequencing (from acceptance to result loaded in the output register):
//   an error goes straight to its result; a read or a dump entry reads the
//   memory and then takes the registered data; an insert or remove moves
//   each entry past pos with a read and a write; a search probes in turn.
//   Each step is one access of the entry memory, whose read data is
//   registered; the sequencer waits for it.
// One request is worked at a time: req.ready is high only while the
// sequencer is idle. A finished result sits in the output register, so the
// next request is taken even while rsp is stalled; a stalled receiver only
// holds up a request once that request has a result of its own to hand over.
// Reset (rst, synchronous) empties the list and drops any pending result.
// Memory contents are not cleared; entries are only read below the count.
// ----------------------------------------------------------------------------
module positional_array_list #(
  parameter int CAPACITY = pal_pkg::DefCapacity
) (
  input  logic       clk,
  input  logic       rst,
  pal_req_if.sink    req,
  pal_rsp_if.source  rsp
);
  import pal_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic      emit_valid;
  logic      emit_ready;
  pal_item_t emit_item;

  // Output register
  logic      out_valid;
  pal_item_t out_item;

  pal_ctrl #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_type   (req.req_type),
    .data_value (req.data_value),
    .slot_index (req.slot_index),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .emit_item  (emit_item)
  );

  // Slot is free when empty or being drained this cycle.
  assign emit_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_valid && emit_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ready) begin
      out_item <= emit_item;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_item.status;
  assign rsp.read_value  = out_item.read_value;
  assign rsp.found_index = out_item.found_index;
  assign rsp.entry_count = out_item.entry_count;
  assign rsp.last        = out_item.last;

endmodule
